/* src/scfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_pkg: shared types and constants
// Result kinds, opcodes, the command word that runs from the front part to
// the back part, and the back sequencer's states.
// ----------------------------------------------------------------------------
package scfe_pkg;

	localparam int TIME_W  = 64;
	localparam int COUNT_W = 32;
	localparam int POINT_W = 5;
	localparam int VALUE_W = 8;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_LVL_W = 2;

	localparam logic OP_SUBMIT = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_FINAL  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HEADER,
		B_SCAN,
		B_TAIL
	} bstate_t;

	typedef struct packed {
		logic               sweep;
		logic               flush;
		logic               upd;
		logic [POINT_W-1:0] point;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0]  hdr_time;
	} cmd_t;

	typedef struct packed {
		logic scanning;
		logic flags_any;
	} bk_status_t;

endpackage

/* src/scfe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_front: input classifier
// Accepts items, tracks the open and swept frame times, and turns each item
// into a command for the back part.
// ----------------------------------------------------------------------------
module scfe_front import scfe_pkg::*; #(
	parameter int NUM_POINTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic [TIME_W-1:0]  sample_time,
	input  logic               has_point,
	input  logic [POINT_W-1:0] point_index,
	input  logic [VALUE_W-1:0] sample_value,
	input  logic               q_full,
	output logic               push,
	output cmd_t               push_cmd
);

	logic              first_q;
	logic [TIME_W-1:0] open_q;
	logic [TIME_W-1:0] swept_q;
	logic              sweep;
	logic              is_flush;
	logic              point_ok;

	assign item_stall = q_full;
	assign push       = item_valid & ~q_full;
	assign is_flush   = (opcode == OP_FLUSH);
	assign point_ok   = (32'(point_index) < 32'(NUM_POINTS));

	always_comb begin
		if (is_flush) begin
			sweep = (open_q != swept_q);
		end else begin
			sweep = !first_q && (sample_time != open_q);
		end
		push_cmd.sweep    = sweep;
		push_cmd.flush    = is_flush;
		push_cmd.upd      = !is_flush && has_point && point_ok;
		push_cmd.point    = point_index;
		push_cmd.value    = sample_value;
		push_cmd.hdr_time = open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			open_q  <= '0;
			swept_q <= '1;
		end else if (push) begin
			// a closed frame is marked swept at its own time
			if (sweep) begin
				swept_q <= open_q;
			end
			if (!is_flush) begin
				open_q  <= sample_time;
				first_q <= 1'b0;
			end
		end
	end

endmodule

/* src/scfe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_queue: command queue
// Two-entry FIFO that decouples the classifier from the frame sequencer.
// ----------------------------------------------------------------------------
module scfe_queue import scfe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cmd_t               push_cmd,
	input  logic               pop,
	output cmd_t               pop_cmd,
	output logic               full,
	output logic               empty,
	output logic [Q_LVL_W-1:0] level
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_LVL_W-1:0] lvl_q;

	assign full    = (lvl_q == Q_LVL_W'(Q_DEPTH));
	assign empty   = (lvl_q == '0);
	assign level   = lvl_q;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			lvl_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				lvl_q <= lvl_q + 1'b1;
			end else if (pop && !push) begin
				lvl_q <= lvl_q - 1'b1;
			end
		end
	end

endmodule

/* src/scfe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_back: frame sequencer
// Holds point values and changed flags, emits headers, changed entries and
// final markers one per cycle unless stalled, and applies sample updates.
// ----------------------------------------------------------------------------
module scfe_back import scfe_pkg::*; #(
	parameter int NUM_POINTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  cmd_t               q_cmd,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         kind,
	output logic [TIME_W-1:0]  frame_time,
	output logic [COUNT_W-1:0] entry_index,
	output logic [POINT_W-1:0] changed_point,
	output logic [VALUE_W-1:0] changed_value,
	output logic               last,
	output bk_status_t         status
);

	localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

	bstate_t              state_q, state_d;
	cmd_t                 cmd_q;
	logic [VALUE_W-1:0]   values_q [NUM_POINTS];
	logic [NUM_POINTS-1:0] flags_q;
	logic [COUNT_W-1:0]   count_q;

	logic                 res_valid_q;
	kind_t                kind_q, kind_d;
	logic [TIME_W-1:0]    time_q, time_d;
	logic [COUNT_W-1:0]   index_q, index_d;
	logic [POINT_W-1:0]   point_q, point_d;
	logic [VALUE_W-1:0]   value_q, value_d;
	logic                 last_q, last_d;

	logic                 slot_free;
	logic                 load;
	logic                 clr;
	logic                 apply;
	logic                 flags_any;
	logic                 more;
	logic [IDX_W-1:0]     sel;
	logic [IDX_W-1:0]     pidx;
	logic [IDX_W-1:0]     rd_idx;
	logic [VALUE_W-1:0]   rd_val;

	assign slot_free = !res_valid_q || !res_stall;
	assign flags_any = |flags_q;
	// more than one flag set: something remains after the lowest one
	assign more      = |(flags_q & (flags_q - NUM_POINTS'(1)));
	assign pidx      = cmd_q.point[IDX_W-1:0];
	assign rd_idx    = (state_q == B_SCAN) ? sel : pidx;
	assign rd_val    = values_q[rd_idx];

	always_comb begin
		sel = '0;
		for (int i = NUM_POINTS - 1; i >= 0; i--) begin
			if (flags_q[i]) begin
				sel = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		clr     = 1'b0;
		apply   = 1'b0;
		kind_d  = KIND_HEADER;
		time_d  = '0;
		index_d = '0;
		point_d = '0;
		value_d = '0;
		last_d  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = q_cmd.sweep ? B_HEADER : B_TAIL;
				end
			end
			B_HEADER: begin
				if (slot_free) begin
					load    = 1'b1;
					kind_d  = KIND_HEADER;
					time_d  = cmd_q.hdr_time;
					index_d = count_q;
					last_d  = !flags_any && !cmd_q.flush;
					state_d = flags_any ? B_SCAN : B_TAIL;
				end
			end
			B_SCAN: begin
				if (slot_free) begin
					load    = 1'b1;
					clr     = 1'b1;
					kind_d  = KIND_ENTRY;
					point_d = POINT_W'(sel);
					value_d = rd_val;
					last_d  = !more && !cmd_q.flush;
					if (!more) begin
						state_d = B_TAIL;
					end
				end
			end
			B_TAIL: begin
				if (cmd_q.flush) begin
					if (slot_free) begin
						load    = 1'b1;
						kind_d  = KIND_FINAL;
						index_d = count_q;
						last_d  = 1'b1;
						state_d = B_IDLE;
					end
				end else begin
					apply   = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			flags_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_POINTS; i++) begin
				values_q[i] <= '1;
			end
		end else begin
			state_q <= state_d;
			if (clr) begin
				flags_q[sel] <= 1'b0;
				count_q      <= count_q + 1'b1;
			end
			if (apply && cmd_q.upd) begin
				// flag only the first change within the frame, always keep latest value
				if (!flags_q[pidx] && (rd_val != cmd_q.value)) begin
					flags_q[pidx] <= 1'b1;
				end
				values_q[pidx] <= cmd_q.value;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (load) begin
			kind_q  <= kind_d;
			time_q  <= time_d;
			index_q <= index_d;
			point_q <= point_d;
			value_q <= value_d;
			last_q  <= last_d;
		end
	end

	assign res_valid        = res_valid_q;
	assign kind             = kind_q;
	assign frame_time       = time_q;
	assign entry_index      = index_q;
	assign changed_point    = point_q;
	assign changed_value    = value_q;
	assign last             = last_q;
	assign status.scanning  = (state_q == B_SCAN);
	assign status.flags_any = flags_any;

endmodule

/* src/sparse_change_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_change_frame_encoder: change-trace frame encoder
// Encodes timestamped point samples as compressed-sparse-row frames.
// ----------------------------------------------------------------------------
// A sample that does not close a frame takes the idle and tail states of the
// frame sequencer; one that closes a frame takes idle, header, a scan step
// per changed point in it and tail, and a flush takes idle and tail, plus
// header and scan when it closes an unswept frame. The sequencer emits one
// result per cycle unless stalled. A two-entry command queue lets the input
// side accept ahead of the sequencer; the result register holds a waiting result.
// ----------------------------------------------------------------------------
module sparse_change_frame_encoder import scfe_pkg::*; #(
	parameter int NUM_POINTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic [TIME_W-1:0]  sample_time,
	input  logic               has_point,
	input  logic [POINT_W-1:0] point_index,
	input  logic [VALUE_W-1:0] sample_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         kind,
	output logic [TIME_W-1:0]  frame_time,
	output logic [COUNT_W-1:0] entry_index,
	output logic [POINT_W-1:0] changed_point,
	output logic [VALUE_W-1:0] changed_value,
	output logic               last
);

	logic               push;
	cmd_t               push_cmd;
	logic               pop;
	cmd_t               pop_cmd;
	logic               q_full;
	logic               q_empty;
	logic [Q_LVL_W-1:0] q_level;
	bk_status_t         bk_status;

	scfe_front #(
		.NUM_POINTS(NUM_POINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.sample_time  (sample_time),
		.has_point    (has_point),
		.point_index  (point_index),
		.sample_value (sample_value),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	scfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty),
		.level    (q_level)
	);

	scfe_back #(
		.NUM_POINTS(NUM_POINTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_cmd         (pop_cmd),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.frame_time    (frame_time),
		.entry_index   (entry_index),
		.changed_point (changed_point),
		.changed_value (changed_value),
		.last          (last),
		.status        (bk_status)
	);

	// an entry scan runs only while some changed flag is still set
	a_scan_has_flags: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.scanning |-> bk_status.flags_any)
		else $error("entry scan with no changed flag set");

	// the final marker always closes the results of a flush
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == KIND_FINAL)) |-> last)
		else $error("final marker without last");

	// the command queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_level <= Q_LVL_W'(Q_DEPTH)) && (item_stall == (q_level == Q_LVL_W'(Q_DEPTH))))
		else $error("command queue level out of bounds");

endmodule
